// ===== rtl/sdr_scalar_encoder_unit_macros.svh =====
// Assertion macros shared by the checker of the scalar encoder.
`ifndef SDR_SCALAR_ENCODER_UNIT_MACROS_SVH
`define SDR_SCALAR_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SSE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sse: same-cycle implication violated");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sse: next-cycle implication violated");

`endif

// ===== rtl/sse_pkg.sv =====
// Widths, reset values and register indexes of the scalar encoder.
package sse_pkg;

    localparam int VAL_W  = 16;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;
    localparam int SIDE_W = 7;
    localparam int AC_W   = 7;
    localparam int SR_W   = 13;
    localparam int SC_W   = 13;
    localparam int NUM_W  = VAL_W + SC_W;
    localparam int PROD_W = 2 * SR_W;
    localparam int POS_W  = 18;
    localparam int ROW_W  = 12;
    localparam int COL_W  = 6;
    localparam int ADDR_W = 12;
    localparam int CNT_W  = 6;

    localparam logic [SIDE_W-1:0] GRID_WIDTH_RST   = 7'd32;
    localparam logic [SIDE_W-1:0] GRID_HEIGHT_RST  = 7'd32;
    localparam logic [AC_W-1:0]   ACTIVE_COUNT_RST = 7'd8;
    localparam logic [SR_W-1:0]   SPREAD_RANGE_RST = 13'd64;
    localparam logic [VAL_W-1:0]  RANGE_LOW_RST    = 16'd0;
    localparam logic [VAL_W-1:0]  RANGE_HIGH_RST   = 16'd0;
    localparam logic [SC_W-1:0]   STEP_COUNT_RST   = 13'd960;

    typedef enum logic [IDX_W-1:0] {
        REG_GRID_WIDTH   = 3'd0,
        REG_GRID_HEIGHT  = 3'd1,
        REG_ACTIVE_COUNT = 3'd2,
        REG_SPREAD_RANGE = 3'd3,
        REG_RANGE_LOW    = 3'd4,
        REG_RANGE_HIGH   = 3'd5,
        REG_STEP_COUNT   = 3'd6
    } cfg_reg_t;

endpackage

// ===== rtl/sse_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side payload.
module sse_div #(
    parameter int ND = 13,
    parameter int DW = 7,
    parameter int PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [ND-1:0] dividend,
    input  logic [DW-1:0] divisor,
    input  logic [PW-1:0] payload,
    output logic          out_valid,
    output logic [ND-1:0] quotient,
    output logic [DW-1:0] remainder,
    output logic [PW-1:0] out_payload
);

    logic          valid_reg [ND];
    logic [ND-1:0] dq_reg    [ND];
    logic [DW-1:0] rem_reg   [ND];
    logic [DW-1:0] dsr_reg   [ND];
    logic [PW-1:0] pay_reg   [ND];

    for (genvar k = 0; k < ND; k++) begin : g_stage
        logic          v_in;
        logic [ND-1:0] dq_in;
        logic [DW-1:0] rem_in;
        logic [DW-1:0] dsr_in;
        logic [PW-1:0] pay_in;
        logic [DW:0]   trial;
        logic          fits;
        logic [DW-1:0] rem_next;
        logic [ND-1:0] dq_next;

        if (k == 0) begin : g_first
            assign v_in   = in_valid;
            assign dq_in  = dividend;
            assign rem_in = '0;
            assign dsr_in = divisor;
            assign pay_in = payload;
        end else begin : g_rest
            assign v_in   = valid_reg[k-1];
            assign dq_in  = dq_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign dsr_in = dsr_reg[k-1];
            assign pay_in = pay_reg[k-1];
        end

        // Bring down the next dividend bit and try the subtraction
        always_comb
        begin
            trial    = {rem_in, dq_in[ND-1]};
            fits     = trial >= {1'b0, dsr_in};
            rem_next = fits ? DW'(trial - {1'b0, dsr_in}) : trial[DW-1:0];
            dq_next  = {dq_in[ND-2:0], fits};
        end

        // Advance the valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= v_in;
            end
        end

        // Advance the working values
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dq_reg[k]  <= dq_next;
                rem_reg[k] <= rem_next;
                dsr_reg[k] <= dsr_in;
                pay_reg[k] <= pay_in;
            end
        end
    end

    assign out_valid   = valid_reg[ND-1];
    assign quotient    = dq_reg[ND-1];
    assign remainder   = rem_reg[ND-1];
    assign out_payload = pay_reg[ND-1];

endmodule

// ===== rtl/sdr_scalar_encoder_unit.sv =====
// Scalar to sparse-cell encoder: each value item yields min(active_count, MAX_ACTIVE) cell
// items (none when that is zero), one per cycle while out_ready does not stall the output;
// a value enters the pipeline in any cycle it is not held back.
// From an accepted value to its first cell item, the value passes the chain of bit-serial
// pipelined dividers (bucket, major bin, minor share, bin split, position split). After
// reset and after every register write the block derives the minor bin size, its
// row/column split and the split of the wrap step, with in_ready low; writes are taken
// at any time.
module sdr_scalar_encoder_unit #(
    parameter int MAX_SIDE   = 64,
    parameter int MAX_ACTIVE = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [sse_pkg::VAL_W-1:0]   value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [sse_pkg::ROW_W-1:0]   cell_row,
    output logic [sse_pkg::COL_W-1:0]   cell_col,
    output logic [sse_pkg::ADDR_W-1:0]  cell_address,
    output logic                        out_of_range,
    output logic                        last,
    input  logic                        cfg_write,
    input  logic [sse_pkg::IDX_W-1:0]   cfg_index,
    input  logic [sse_pkg::CFG_W-1:0]   cfg_data
);

    import sse_pkg::*;

    localparam int VB = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
    localparam logic [VAL_W-1:0] VMASK = VAL_W'((17'd1 << VB) - 17'd1);

    // Configuration registers
    logic [SIDE_W-1:0] grid_width_reg;
    logic [SIDE_W-1:0] grid_height_reg;
    logic [AC_W-1:0]   active_count_reg;
    logic [SR_W-1:0]   spread_range_reg;
    logic [VAL_W-1:0]  range_low_reg;
    logic [VAL_W-1:0]  range_high_reg;
    logic [SC_W-1:0]   step_count_reg;

    // Derived configuration
    logic [VAL_W-1:0]  hi_val;
    logic              span_ok;
    logic [VAL_W-1:0]  span;
    logic [SR_W-1:0]   sr_eff;
    logic [AC_W-1:0]   ac_eff;
    logic [AC_W-1:0]   ac_div;
    logic              ac_zero;
    logic [SIDE_W-1:0] div_eff;

    // Minor bin constants, filled by the setup chain
    logic              start_reg;
    logic [CNT_W-1:0]  inflight_reg;
    logic [CNT_W-1:0]  inflight_next;
    logic              cfg_ready;
    logic [SR_W-1:0]   mbs_reg;
    logic [SR_W-1:0]   mq_reg;
    logic [SIDE_W-1:0] mr_reg;
    logic [SR_W-1:0]   eq_reg;
    logic [SIDE_W-1:0] er_reg;

    logic              c1_valid;
    logic [SR_W-1:0]   c1_quot;
    logic [SIDE_W-1:0] c1_pay;
    logic [SR_W-1:0]   mbs_new;
    logic              c2_valid;
    logic [SR_W-1:0]   c2_quot;
    logic [SIDE_W-1:0] c2_rem;
    logic [SIDE_W+SR_W-1:0] c2_pay;
    logic [SR_W-1:0]   c2_mbs;
    logic [SIDE_W-1:0] c2_div;
    logic [SR_W-1:0]   extra_step;
    logic              c3_valid;
    logic [SR_W-1:0]   c3_quot;
    logic [SIDE_W-1:0] c3_rem;
    logic [2*SR_W+SIDE_W-1:0] c3_pay;

    // Main pipeline
    logic              adv;
    logic [VAL_W-1:0]  v_in;
    logic [VAL_W-1:0]  v_clamp;
    logic [VAL_W-1:0]  a_diff_next;
    logic              a_bad_next;
    logic              a_athi_next;
    logic              a_valid_reg;
    logic [VAL_W-1:0]  a_diff_reg;
    logic              a_bad_reg;
    logic              a_athi_reg;
    logic              b_valid_reg;
    logic [NUM_W-1:0]  b_num_reg;
    logic              b_bad_reg;
    logic              b_athi_reg;

    logic              d1_valid;
    logic [NUM_W-1:0]  d1_quot;
    logic [1:0]        d1_pay;
    logic [SR_W-1:0]   bucket;

    logic              d2_valid;
    logic [SR_W-1:0]   d2_quot;
    logic [SR_W-1:0]   d2_rem;
    logic              d2_pay;

    logic              d3_valid;
    logic [SR_W-1:0]   d3_quot;
    logic [AC_W-1:0]   d3_rem;
    logic [SR_W:0]     d3_pay;

    logic              d4_valid;
    logic [SR_W-1:0]   d4_quot;
    logic [SR_W-1:0]   d4_rem;
    logic [SR_W+AC_W:0] d4_pay;

    logic              m_valid_reg;
    logic [PROD_W-1:0] m_base_reg;
    logic [PROD_W-1:0] m_prod_reg;
    logic [SR_W-1:0]   m_b_reg;
    logic              m_wrap_reg;
    logic              m_bad_reg;
    logic [AC_W-1:0]   m_r_reg;

    logic              s_valid_reg;
    logic [POS_W-1:0]  s_pos_reg;
    logic              s_wrap_reg;
    logic              s_bad_reg;
    logic [AC_W-1:0]   s_r_reg;

    logic              d5_valid;
    logic [POS_W-1:0]  d5_quot;
    logic [SIDE_W-1:0] d5_rem;
    logic [AC_W+1:0]   d5_pay;

    logic [SIDE_W:0]   f_csum;
    logic              f_carry;
    logic              f_valid_reg;
    logic [POS_W-1:0]  f_r0_reg;
    logic [SIDE_W-1:0] f_c0_reg;
    logic [POS_W-1:0]  f_r1_reg;
    logic [SIDE_W-1:0] f_c1_reg;
    logic              f_bad_reg;
    logic [AC_W-1:0]   f_rr_reg;

    // Cell expander
    logic              x_busy_reg;
    logic [AC_W-1:0]   x_i_reg;
    logic [POS_W-1:0]  x_r0_reg;
    logic [SIDE_W-1:0] x_c0_reg;
    logic [POS_W-1:0]  x_r1_reg;
    logic [SIDE_W-1:0] x_c1_reg;
    logic              x_bad_reg;
    logic [AC_W-1:0]   x_rr_reg;
    logic [POS_W-1:0]  x_arow_reg;
    logic [SIDE_W-1:0] x_acol_reg;
    logic              x_emit;
    logic              x_last;
    logic              x_take;
    logic              x_load;
    logic [POS_W-1:0]  pr;
    logic [SIDE_W-1:0] pc;
    logic [SIDE_W:0]   csum;
    logic              cwrap;
    logic [SIDE_W-1:0] col;
    logic [POS_W-1:0]  row;
    logic              cell_bad;
    logic [ADDR_W-1:0] addr;
    logic [SIDE_W:0]   asum;
    logic              awrap;

    logic              out_valid_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic              out_bad_reg;
    logic              out_last_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg   <= GRID_WIDTH_RST;
            grid_height_reg  <= GRID_HEIGHT_RST;
            active_count_reg <= ACTIVE_COUNT_RST;
            spread_range_reg <= SPREAD_RANGE_RST;
            range_low_reg    <= RANGE_LOW_RST;
            range_high_reg   <= RANGE_HIGH_RST;
            step_count_reg   <= STEP_COUNT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GRID_WIDTH:   grid_width_reg   <= cfg_data[SIDE_W-1:0];
                REG_GRID_HEIGHT:  grid_height_reg  <= cfg_data[SIDE_W-1:0];
                REG_ACTIVE_COUNT: active_count_reg <= cfg_data[AC_W-1:0];
                REG_SPREAD_RANGE: spread_range_reg <= cfg_data[SR_W-1:0];
                REG_RANGE_LOW:    range_low_reg    <= cfg_data[VAL_W-1:0];
                REG_RANGE_HIGH:   range_high_reg   <= cfg_data[VAL_W-1:0];
                REG_STEP_COUNT:   step_count_reg   <= cfg_data[SC_W-1:0];
                default:          ;
            endcase
        end
    end

    // Resolve effective range, spread, count and divisor
    always_comb
    begin
        hi_val  = (range_low_reg == '0 && range_high_reg == '0) ?
                  VAL_W'(step_count_reg) : range_high_reg;
        span_ok = hi_val > range_low_reg;
        span    = span_ok ? VAL_W'(hi_val - range_low_reg) : VAL_W'(1);
        sr_eff  = (spread_range_reg == '0) ? SR_W'(1) : spread_range_reg;
        ac_eff  = (active_count_reg > AC_W'(MAX_ACTIVE)) ? AC_W'(MAX_ACTIVE)
                                                         : active_count_reg;
        ac_zero = (ac_eff == '0);
        ac_div  = ac_zero ? AC_W'(1) : ac_eff;
        div_eff = (grid_height_reg == '0) ? SIDE_W'(1) : grid_height_reg;
    end

    // Setup chain: minor bin size, then its split and the wrap step by the divisor
    always_comb
    begin
        inflight_next = inflight_reg + CNT_W'(start_reg) - CNT_W'(c3_valid);
        cfg_ready     = (inflight_reg == '0) && !start_reg;
        mbs_new       = (c1_quot == '0) ? SR_W'(1) : c1_quot;
        c2_div        = c2_pay[SIDE_W+SR_W-1:SR_W];
        c2_mbs        = c2_pay[SR_W-1:0];
        extra_step    = SR_W'(sr_eff - c2_mbs + SR_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg    <= 1'b1;
            inflight_reg <= '0;
        end
        else
        begin
            start_reg    <= cfg_write;
            inflight_reg <= inflight_next;
        end
    end

    // Hold the latest setup result
    always_ff @(posedge clk)
    begin
        if (c3_valid)
        begin
            mbs_reg <= c3_pay[2*SR_W+SIDE_W-1:SR_W+SIDE_W];
            mq_reg  <= c3_pay[SR_W+SIDE_W-1:SIDE_W];
            mr_reg  <= c3_pay[SIDE_W-1:0];
            eq_reg  <= c3_quot;
            er_reg  <= c3_rem;
        end
    end

    sse_div #(.ND(SR_W), .DW(AC_W), .PW(SIDE_W)) u_div_mbs (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (1'b1),
        .in_valid    (start_reg),
        .dividend    (sr_eff),
        .divisor     (ac_div),
        .payload     (div_eff),
        .out_valid   (c1_valid),
        .quotient    (c1_quot),
        .remainder   (),
        .out_payload (c1_pay)
    );

    sse_div #(.ND(SR_W), .DW(SIDE_W), .PW(SIDE_W+SR_W)) u_div_mbs_split (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (1'b1),
        .in_valid    (c1_valid),
        .dividend    (mbs_new),
        .divisor     (c1_pay),
        .payload     ({c1_pay, mbs_new}),
        .out_valid   (c2_valid),
        .quotient    (c2_quot),
        .remainder   (c2_rem),
        .out_payload (c2_pay)
    );

    sse_div #(.ND(SR_W), .DW(SIDE_W), .PW(2*SR_W+SIDE_W)) u_div_wrap_split (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (1'b1),
        .in_valid    (c2_valid),
        .dividend    (extra_step),
        .divisor     (c2_div),
        .payload     ({c2_mbs, c2_quot, c2_rem}),
        .out_valid   (c3_valid),
        .quotient    (c3_quot),
        .remainder   (c3_rem),
        .out_payload (c3_pay)
    );

    // Stall the pipeline only when the expander cannot take the finished item
    assign x_take   = !x_busy_reg || (x_emit && x_last);
    assign adv      = !f_valid_reg || ac_zero || x_take;
    assign x_load   = adv && f_valid_reg && !ac_zero;
    assign in_ready = adv && cfg_ready;

    // Stage A: clamp the value into the range
    always_comb
    begin
        v_in        = value & VMASK;
        v_clamp     = v_in;
        a_diff_next = '0;
        a_bad_next  = (v_in != range_low_reg);
        a_athi_next = 1'b0;
        if (span_ok)
        begin
            a_bad_next = 1'b0;
            if (v_in < range_low_reg)
            begin
                v_clamp    = range_low_reg;
                a_bad_next = 1'b1;
            end
            else if (v_in > hi_val)
            begin
                v_clamp    = hi_val;
                a_bad_next = 1'b1;
            end
            a_diff_next = VAL_W'(v_clamp - range_low_reg);
            a_athi_next = (v_clamp == hi_val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid && cfg_ready;
            b_valid_reg <= a_valid_reg;
            m_valid_reg <= d4_valid;
            s_valid_reg <= m_valid_reg;
            f_valid_reg <= d5_valid;
        end
    end

    // Stages A and B: scale the offset by the step count
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_diff_reg <= a_diff_next;
            a_bad_reg  <= a_bad_next;
            a_athi_reg <= a_athi_next;
            b_num_reg  <= NUM_W'(a_diff_reg) * NUM_W'(step_count_reg);
            b_bad_reg  <= a_bad_reg;
            b_athi_reg <= a_athi_reg;
        end
    end

    sse_div #(.ND(NUM_W), .DW(VAL_W), .PW(2)) u_div_bucket (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv),
        .in_valid    (b_valid_reg),
        .dividend    (b_num_reg),
        .divisor     (span),
        .payload     ({b_bad_reg, b_athi_reg}),
        .out_valid   (d1_valid),
        .quotient    (d1_quot),
        .remainder   (),
        .out_payload (d1_pay)
    );

    // Pull the top value back into the last bucket
    assign bucket = (d1_pay[0] && d1_quot[SR_W-1:0] != '0) ?
                    SR_W'(d1_quot[SR_W-1:0] - SR_W'(1)) : d1_quot[SR_W-1:0];

    sse_div #(.ND(SR_W), .DW(SR_W), .PW(1)) u_div_major (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv),
        .in_valid    (d1_valid),
        .dividend    (bucket),
        .divisor     (sr_eff),
        .payload     (d1_pay[1]),
        .out_valid   (d2_valid),
        .quotient    (d2_quot),
        .remainder   (d2_rem),
        .out_payload (d2_pay)
    );

    sse_div #(.ND(SR_W), .DW(AC_W), .PW(SR_W+1)) u_div_share (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv),
        .in_valid    (d2_valid),
        .dividend    (d2_rem),
        .divisor     (ac_div),
        .payload     ({d2_pay, d2_quot}),
        .out_valid   (d3_valid),
        .quotient    (d3_quot),
        .remainder   (d3_rem),
        .out_payload (d3_pay)
    );

    sse_div #(.ND(SR_W), .DW(SR_W), .PW(SR_W+AC_W+1)) u_div_bin (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv),
        .in_valid    (d3_valid),
        .dividend    (d3_quot),
        .divisor     (mbs_reg),
        .payload     ({d3_pay, d3_rem}),
        .out_valid   (d4_valid),
        .quotient    (d4_quot),
        .remainder   (d4_rem),
        .out_payload (d4_pay)
    );

    // Stage M: major base and whole-bin offset; Stage S: base position
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_base_reg <= PROD_W'(d4_pay[SR_W+AC_W-1:AC_W]) * PROD_W'(sr_eff);
            m_prod_reg <= PROD_W'(d4_quot) * PROD_W'(sr_eff);
            m_b_reg    <= d4_rem;
            m_wrap_reg <= (({1'b0, d4_rem} + (SR_W+1)'(1)) == {1'b0, mbs_reg});
            m_bad_reg  <= d4_pay[SR_W+AC_W];
            m_r_reg    <= d4_pay[AC_W-1:0];
            s_pos_reg  <= POS_W'(m_base_reg + m_prod_reg + PROD_W'(m_b_reg));
            s_wrap_reg <= m_wrap_reg;
            s_bad_reg  <= m_bad_reg;
            s_r_reg    <= m_r_reg;
        end
    end

    sse_div #(.ND(POS_W), .DW(SIDE_W), .PW(AC_W+2)) u_div_pos (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv),
        .in_valid    (s_valid_reg),
        .dividend    (s_pos_reg),
        .divisor     (div_eff),
        .payload     ({s_bad_reg, s_r_reg, s_wrap_reg}),
        .out_valid   (d5_valid),
        .quotient    (d5_quot),
        .remainder   (d5_rem),
        .out_payload (d5_pay)
    );

    // Stage F: split of the position one minor share further on
    always_comb
    begin
        f_csum  = {1'b0, d5_rem} + (d5_pay[0] ? {1'b0, er_reg} : (SIDE_W+1)'(1));
        f_carry = f_csum >= {1'b0, div_eff};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_r0_reg  <= d5_quot;
            f_c0_reg  <= d5_rem;
            f_r1_reg  <= d5_quot + (d5_pay[0] ? POS_W'(eq_reg) : '0) + POS_W'(f_carry);
            f_c1_reg  <= f_carry ? SIDE_W'(f_csum - {1'b0, div_eff}) : f_csum[SIDE_W-1:0];
            f_bad_reg <= d5_pay[AC_W+1];
            f_rr_reg  <= d5_pay[AC_W:1];
        end
    end

    // Expander: form the current cell from the base split and the running offset
    always_comb
    begin
        x_emit   = x_busy_reg && (!out_valid_reg || out_ready);
        x_last   = (x_i_reg + AC_W'(1)) == ac_eff;
        pr       = (x_i_reg < x_rr_reg) ? x_r1_reg : x_r0_reg;
        pc       = (x_i_reg < x_rr_reg) ? x_c1_reg : x_c0_reg;
        csum     = {1'b0, pc} + {1'b0, x_acol_reg};
        cwrap    = csum >= {1'b0, div_eff};
        col      = cwrap ? SIDE_W'(csum - {1'b0, div_eff}) : csum[SIDE_W-1:0];
        row      = pr + x_arow_reg + POS_W'(cwrap);
        cell_bad = x_bad_reg || (grid_height_reg == '0) ||
                   (row >= POS_W'(grid_width_reg)) || (row >= POS_W'(MAX_SIDE)) ||
                   (POS_W'(col) >= POS_W'(MAX_SIDE));
        addr     = (ADDR_W'(col) * ADDR_W'(grid_width_reg)) + row[ADDR_W-1:0];
        asum     = {1'b0, x_acol_reg} + {1'b0, mr_reg};
        awrap    = asum >= {1'b0, div_eff};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_busy_reg <= 1'b0;
        end
        else if (x_load)
        begin
            x_busy_reg <= 1'b1;
        end
        else if (x_emit && x_last)
        begin
            x_busy_reg <= 1'b0;
        end
    end

    // Load a new item or step to the next cell
    always_ff @(posedge clk)
    begin
        if (x_load)
        begin
            x_i_reg    <= '0;
            x_r0_reg   <= f_r0_reg;
            x_c0_reg   <= f_c0_reg;
            x_r1_reg   <= f_r1_reg;
            x_c1_reg   <= f_c1_reg;
            x_bad_reg  <= f_bad_reg;
            x_rr_reg   <= f_rr_reg;
            x_arow_reg <= '0;
            x_acol_reg <= '0;
        end
        else if (x_emit)
        begin
            x_i_reg    <= x_i_reg + AC_W'(1);
            x_arow_reg <= x_arow_reg + POS_W'(mq_reg) + POS_W'(awrap);
            x_acol_reg <= awrap ? SIDE_W'(asum - {1'b0, div_eff}) : asum[SIDE_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (x_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (x_emit)
        begin
            out_row_reg  <= row[ROW_W-1:0];
            out_col_reg  <= col[COL_W-1:0];
            out_addr_reg <= addr;
            out_bad_reg  <= cell_bad;
            out_last_reg <= x_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cell_row     = out_row_reg;
    assign cell_col     = out_col_reg;
    assign cell_address = out_addr_reg;
    assign out_of_range = out_bad_reg;
    assign last         = out_last_reg;

endmodule

// ===== rtl/sse_checker.sv =====
// Port-level checker of the scalar encoder and its bind to the top level.
`include "sdr_scalar_encoder_unit_macros.svh"

module sse_checker #(
    parameter int MAX_SIDE = 64
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic [sse_pkg::VAL_W-1:0]   value,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [sse_pkg::ROW_W-1:0]   cell_row,
    input logic [sse_pkg::COL_W-1:0]   cell_col,
    input logic [sse_pkg::ADDR_W-1:0]  cell_address,
    input logic                        out_of_range,
    input logic                        last,
    input logic                        cfg_write,
    input logic [sse_pkg::IDX_W-1:0]   cfg_index,
    input logic [sse_pkg::CFG_W-1:0]   cfg_data
);

    import sse_pkg::*;

    // Hold a stalled cell item
    `SSE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(cell_row) && $stable(cell_col) && $stable(cell_address) && $stable(out_of_range) && $stable(last))

    // An in-grid cell lies inside the side limit
    `SSE_ASSERT_IMP(a_row_in_grid, out_valid && !out_of_range, int'(cell_row) < MAX_SIDE)
    `SSE_ASSERT_IMP(a_col_in_grid, out_valid && !out_of_range, int'(cell_col) < MAX_SIDE)

    // Drop ready while the minor bin constants are rebuilt
    `SSE_ASSERT_NEXT(a_cfg_blocks, cfg_write, !in_ready)

endmodule

bind sdr_scalar_encoder_unit sse_checker #(.MAX_SIDE(MAX_SIDE)) u_sse_checker (.*);
